@@ sv/pcca_pkg.sv @@
// ----------------------------------------------------------------------------
// pcca_pkg
// Types and constants shared by the pair collision correction accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcca_pkg;

    localparam int POS_W   = 32;
    localparam int CH_W    = 3;
    localparam int MASK_W  = 8;
    localparam int RAD_W   = 24;
    localparam int GAIN_W  = 16;
    localparam int NBR_W   = 8;
    localparam int CNT_W   = 8;
    localparam int DMIN_W  = RAD_W + 1;          // contact distance
    localparam int DSQ_W   = 2 * DMIN_W + 2;     // sum of three squares
    localparam int ROOT_W  = DSQ_W / 2;
    localparam int PROD_W  = DMIN_W + GAIN_W;    // |pen| * gain
    localparam int GAIN_FRAC = 13;               // Q4.12 gain plus the half
    localparam int CMAG_W  = PROD_W - GAIN_FRAC + 1;
    localparam int NUM_W   = DMIN_W + CMAG_W;
    localparam int QUO_W   = CMAG_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PUSH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NBR  = 2'd3;

    typedef struct packed {
        logic signed [POS_W-1:0] self_x;
        logic signed [POS_W-1:0] self_y;
        logic signed [POS_W-1:0] self_z;
        logic signed [POS_W-1:0] nbr_x;
        logic signed [POS_W-1:0] nbr_y;
        logic signed [POS_W-1:0] nbr_z;
        logic [CH_W-1:0]         self_channel;
        logic [MASK_W-1:0]       self_mask;
        logic [CH_W-1:0]         nbr_channel;
        logic [MASK_W-1:0]       nbr_mask;
        logic                    skip;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] corr_x;
        logic signed [POS_W-1:0] corr_y;
        logic signed [POS_W-1:0] corr_z;
        logic [CNT_W-1:0]        pair_count;
        logic [POS_W-1:0]        corr_sum;
    } out_item_t;

    typedef struct packed {
        logic [RAD_W-1:0]  collision_radius;
        logic [GAIN_W-1:0] relaxation_factor;
        logic [GAIN_W-1:0] max_push_coefficient;
        logic [NBR_W-1:0]  max_neighbors;
    } cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [DMIN_W-1:0] ax;
        logic [DMIN_W-1:0] ay;
        logic [DMIN_W-1:0] az;
        logic              nx;
        logic              ny;
        logic              nz;
        logic              hit;
        logic              last;
    } job_t;

endpackage

`default_nettype wire

@@ sv/pcca_if.sv @@
// ----------------------------------------------------------------------------
// pcca_in_if / pcca_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcca_in_if;
    logic              valid;
    logic              ready;
    pcca_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcca_out_if;
    logic               valid;
    logic               ready;
    pcca_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/pcca_front.sv @@
// ----------------------------------------------------------------------------
// pcca_front
// Accepts items, tracks the neighbor count and prefilters each pair.
// ----------------------------------------------------------------------------
`default_nettype none

module pcca_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcca_pkg::cfg_t cfg,
    pcca_in_if.sink             in_ch,
    output pcca_pkg::job_t      push_job,
    output logic                push,
    input  wire logic           full
);
    import pcca_pkg::*;

    logic [CNT_W-1:0]  seen_reg;
    logic [CNT_W-1:0]  seen_next;
    logic [DMIN_W-1:0] dmin;
    logic [POS_W:0]    dx, dy, dz;
    logic [POS_W:0]    mx, my, mz;
    logic              in_range, admit, near;

    assign dmin = {cfg.collision_radius, 1'b0};

    assign dx = {in_ch.data.nbr_x[POS_W-1], in_ch.data.nbr_x}
              - {in_ch.data.self_x[POS_W-1], in_ch.data.self_x};
    assign dy = {in_ch.data.nbr_y[POS_W-1], in_ch.data.nbr_y}
              - {in_ch.data.self_y[POS_W-1], in_ch.data.self_y};
    assign dz = {in_ch.data.nbr_z[POS_W-1], in_ch.data.nbr_z}
              - {in_ch.data.self_z[POS_W-1], in_ch.data.self_z};
    assign mx = dx[POS_W] ? -dx : dx;
    assign my = dy[POS_W] ? -dy : dy;
    assign mz = dz[POS_W] ? -dz : dz;

    assign in_range = seen_reg < cfg.max_neighbors;
    assign admit  = in_ch.data.self_mask[in_ch.data.nbr_channel]
                  & in_ch.data.nbr_mask[in_ch.data.self_channel];
    assign near   = (dmin != '0)
                  && (mx < {{(POS_W+1-DMIN_W){1'b0}}, dmin})
                  && (my < {{(POS_W+1-DMIN_W){1'b0}}, dmin})
                  && (mz < {{(POS_W+1-DMIN_W){1'b0}}, dmin});

    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;

    always_comb
    begin
        push_job.ax   = mx[DMIN_W-1:0];
        push_job.ay   = my[DMIN_W-1:0];
        push_job.az   = mz[DMIN_W-1:0];
        push_job.nx   = dx[POS_W];
        push_job.ny   = dy[POS_W];
        push_job.nz   = dz[POS_W];
        push_job.hit  = in_range && !in_ch.data.skip && admit && near;
        push_job.last = in_ch.data.last;
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (push)
        begin
            if (in_ch.data.last)
                seen_next = '0;
            else if (seen_reg != {CNT_W{1'b1}})
                seen_next = seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= '0;
        else
            seen_reg <= seen_next;
    end

endmodule

`default_nettype wire

@@ sv/pcca_queue.sv @@
// ----------------------------------------------------------------------------
// pcca_queue
// Two-entry register queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pcca_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pcca_pkg::job_t push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                avail,
    output pcca_pkg::job_t      head
);
    import pcca_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign avail = cnt_reg != 2'd0;
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

`default_nettype wire

@@ sv/pcca_back.sv @@
// ----------------------------------------------------------------------------
// pcca_back
// Solves one contact with a serial square root and serial divisions,
// accumulates the corrections and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcca_back #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pcca_pkg::cfg_t cfg,
    input  wire logic           avail,
    input  wire pcca_pkg::job_t head,
    output logic                pop,
    pcca_out_if.source          out_ch
);
    import pcca_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_PEN   = 4'd4;
    localparam logic [3:0] S_CMAG  = 4'd5;
    localparam logic [3:0] S_NUM   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;
    localparam logic [3:0] S_TALLY = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;

    localparam logic [DMIN_W-1:0] ONE = DMIN_W'(1) << FRACTION_BITS;
    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (GAIN_FRAC - 1);

    logic [3:0]              state_reg, state_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [1:0]              k_reg, k_next;
    logic [DMIN_W-1:0]       a_reg [3];
    logic [DMIN_W-1:0]       a_next [3];
    logic [2:0]              n_reg, n_next;
    logic                    last_reg, last_next;
    logic [DSQ_W-1:0]        dsq_reg, dsq_next;
    logic [2*DMIN_W-1:0]     dmin2_reg, dmin2_next;
    logic [DSQ_W-1:0]        sqv_reg, sqv_next;
    logic [ROOT_W+1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    logic [DMIN_W-1:0]       dist_reg, dist_next;
    logic                    cneg_reg, cneg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [CMAG_W-1:0]       cmag_reg, cmag_next;
    logic [NUM_W-1:0]        numer_reg, numer_next;
    logic [DMIN_W-1:0]       drem_reg, drem_next;
    logic [QUO_W-1:0]        quo_reg, quo_next;
    logic signed [POS_W-1:0] acc_reg [3];
    logic signed [POS_W-1:0] acc_next [3];
    logic [CNT_W-1:0]        pairs_reg, pairs_next;
    logic [POS_W-1:0]        mag_reg, mag_next;
    logic                    ovalid_reg, ovalid_next;
    out_item_t               odata_reg, odata_next;

    logic [DMIN_W-1:0]       dmin;
    logic [GAIN_W-1:0]       g_lo, g_hi;
    logic [2*DMIN_W-1:0]     sq_prod;
    logic [ROOT_W+1:0]       sq_try, sq_trial;
    logic [DMIN_W:0]         dv_try;
    logic [DMIN_W+1:0]       pen;
    logic [DMIN_W-1:0]       pen_mag;
    logic [DMIN_W-1:0]       dist_w;
    logic [POS_W+1:0]        acc_sum;
    logic [QUO_W:0]          q_signed;
    logic [POS_W:0]          mag_sum;

    assign dmin = {cfg.collision_radius, 1'b0};
    assign g_lo = (cfg.relaxation_factor < cfg.max_push_coefficient)
                ? cfg.relaxation_factor : cfg.max_push_coefficient;
    assign g_hi = (cfg.relaxation_factor < cfg.max_push_coefficient)
                ? cfg.max_push_coefficient : cfg.relaxation_factor;

    assign sq_prod  = {{DMIN_W{1'b0}}, a_reg[k_reg]} * {{DMIN_W{1'b0}}, a_reg[k_reg]};
    assign sq_try   = {rem_reg[ROOT_W-1:0], sqv_reg[DSQ_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign dv_try   = {drem_reg, numer_reg[NUM_W-1]};
    assign dist_w   = (root_reg == '0) ? ONE : root_reg[DMIN_W-1:0];
    assign pen      = {2'b00, dmin} - {2'b00, dist_w};
    assign pen_mag  = pen[DMIN_W+1] ? DMIN_W'(-pen) : pen[DMIN_W-1:0];

    // Sign of the quotient follows -delta * c
    assign q_signed = (n_reg[k_reg] == cneg_reg) ? -{1'b0, quo_reg} : {1'b0, quo_reg};
    assign acc_sum  = {{2{acc_reg[k_reg][POS_W-1]}}, acc_reg[k_reg]}
                    + {{(POS_W+1-QUO_W){q_signed[QUO_W]}}, q_signed};
    assign mag_sum  = {1'b0, mag_reg} + {{(POS_W+1-CMAG_W){1'b0}}, cmag_reg};

    assign pop          = (state_reg == S_IDLE) && avail;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = odata_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        n_next      = n_reg;
        last_next   = last_reg;
        dsq_next    = dsq_reg;
        dmin2_next  = dmin2_reg;
        sqv_next    = sqv_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        dist_next   = dist_reg;
        cneg_next   = cneg_reg;
        prod_next   = prod_reg;
        cmag_next   = cmag_reg;
        numer_next  = numer_reg;
        drem_next   = drem_reg;
        quo_next    = quo_reg;
        acc_next    = acc_reg;
        pairs_next  = pairs_reg;
        mag_next    = mag_reg;
        odata_next  = odata_reg;
        ovalid_next = ovalid_reg && !out_ch.ready;

        case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    a_next[0] = head.ax;
                    a_next[1] = head.ay;
                    a_next[2] = head.az;
                    n_next    = {head.nz, head.ny, head.nx};
                    last_next = head.last;
                    dsq_next  = '0;
                    k_next    = 2'd0;
                    state_next = head.hit ? S_MUL : S_FIN;
                end
            end
            S_MUL:
            begin
                // three squares, then the squared contact distance
                if (k_reg == 2'd3)
                begin
                    dmin2_next = {{DMIN_W{1'b0}}, dmin} * {{DMIN_W{1'b0}}, dmin};
                    state_next = S_CMP;
                end
                else
                begin
                    dsq_next = dsq_reg + DSQ_W'(sq_prod);
                    k_next   = k_reg + 1'b1;
                end
            end
            S_CMP:
            begin
                sqv_next  = dsq_reg;
                rem_next  = '0;
                root_next = '0;
                cnt_next  = '0;
                state_next = (dsq_reg >= DSQ_W'(dmin2_reg)) ? S_FIN : S_SQRT;
            end
            S_SQRT:
            begin
                sqv_next = sqv_reg << 2;
                if (sq_try >= sq_trial)
                begin
                    rem_next  = sq_try - sq_trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = sq_try;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(ROOT_W - 1))
                    state_next = S_PEN;
            end
            S_PEN:
            begin
                // coincident points push along minus x over one unit
                if (root_reg == '0)
                begin
                    a_next[0] = ONE;
                    a_next[1] = '0;
                    a_next[2] = '0;
                    n_next    = 3'b000;
                end
                dist_next = dist_w;
                cneg_next = pen[DMIN_W+1];
                prod_next = pen_mag * (pen[DMIN_W+1] ? g_hi : g_lo);
                state_next = S_CMAG;
            end
            S_CMAG:
            begin
                cmag_next  = CMAG_W'((prod_reg + RND) >> GAIN_FRAC);
                k_next     = 2'd0;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                numer_next = NUM_W'(a_reg[k_reg]) * NUM_W'(cmag_reg)
                           + NUM_W'(dist_reg >> 1);
                state_next = S_DIV;
                cnt_next   = '0;
                drem_next  = '0;
                quo_next   = '0;
            end
            S_DIV:
            begin
                if (cnt_reg == 5'd0)
                begin
                    // the quotient is known to fit, so start on the high part
                    drem_next  = numer_reg[NUM_W-1 -: DMIN_W];
                    numer_next = numer_reg << DMIN_W;
                    cnt_next   = 5'd1;
                end
                else
                begin
                    numer_next = numer_reg << 1;
                    if (dv_try >= {1'b0, dist_reg})
                    begin
                        drem_next = DMIN_W'(dv_try - {1'b0, dist_reg});
                        quo_next  = {quo_reg[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = dv_try[DMIN_W-1:0];
                        quo_next  = {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 5'(QUO_W))
                        state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (acc_sum[POS_W+1:POS_W-1] == 3'b000
                    || acc_sum[POS_W+1:POS_W-1] == 3'b111)
                    acc_next[k_reg] = acc_sum[POS_W-1:0];
                else if (acc_sum[POS_W+1])
                    acc_next[k_reg] = {1'b1, {(POS_W-1){1'b0}}};
                else
                    acc_next[k_reg] = {1'b0, {(POS_W-1){1'b1}}};
                if (k_reg == 2'd2)
                    state_next = S_TALLY;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_NUM;
                end
            end
            S_TALLY:
            begin
                if (pairs_reg != {CNT_W{1'b1}})
                    pairs_next = pairs_reg + 1'b1;
                mag_next   = mag_sum[POS_W] ? {POS_W{1'b1}} : mag_sum[POS_W-1:0];
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else if (!ovalid_reg || out_ch.ready)
                begin
                    odata_next.corr_x     = acc_reg[0];
                    odata_next.corr_y     = acc_reg[1];
                    odata_next.corr_z     = acc_reg[2];
                    odata_next.pair_count = pairs_reg;
                    odata_next.corr_sum   = mag_reg;
                    ovalid_next = 1'b1;
                    acc_next[0] = '0;
                    acc_next[1] = '0;
                    acc_next[2] = '0;
                    pairs_next  = '0;
                    mag_next    = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
            pairs_reg  <= '0;
            mag_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            acc_reg    <= acc_next;
            pairs_reg  <= pairs_next;
            mag_reg    <= mag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        k_reg     <= k_next;
        a_reg     <= a_next;
        n_reg     <= n_next;
        last_reg  <= last_next;
        dsq_reg   <= dsq_next;
        dmin2_reg <= dmin2_next;
        sqv_reg   <= sqv_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        dist_reg  <= dist_next;
        cneg_reg  <= cneg_next;
        prod_reg  <= prod_next;
        cmag_reg  <= cmag_next;
        numer_reg <= numer_next;
        drem_reg  <= drem_next;
        quo_reg   <= quo_next;
        odata_reg <= odata_next;
    end

endmodule

`default_nettype wire

@@ sv/pair_collision_correction_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// pair_collision_correction_accumulator_top
// Sums sphere contact corrections over the neighbor list of one agent.
// ----------------------------------------------------------------------------
// in_ch carries one neighbor of one agent per item; out_ch carries one result
// per agent, issued after the item marked last. Both use valid/ready.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, since the block does not enforce it. The front
// classifies an item in the cycle it is accepted and pushes it into a
// two-entry queue; the back drains the queue one item at a time. An item that
// fails the prefilter passes through S_IDLE and S_FIN in the back; one that
// misses the contact sphere also passes through the multiply and compare
// states. A colliding pair takes the multiply steps, a 26-step square root
// and three divisions by the distance (product, load, 29 steps, accumulate),
// all on the one serial datapath. The result is loaded in S_FIN once the back
// has finished a last item, colliding or not, and the old result is taken.
// Reset clears the sums, the neighbor count, the queue and the result valid,
// and loads the register defaults. A stalled receiver holds the result; the
// back then waits on the next last item and the queue fills up and stalls
// in_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_collision_correction_accumulator_top #(
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pcca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcca_pkg::CFG_DATA_W-1:0]   cfg_data,
    pcca_in_if.sink                                in_ch,
    pcca_out_if.source                             out_ch
);
    import pcca_pkg::*;

    cfg_t cfg_reg;
    job_t push_job, head;
    logic push, full, pop, avail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.collision_radius     <= RAD_W'(10240);
            cfg_reg.relaxation_factor    <= GAIN_W'(4096);
            cfg_reg.max_push_coefficient <= GAIN_W'(4096);
            cfg_reg.max_neighbors        <= NBR_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:   cfg_reg.collision_radius     <= cfg_data[RAD_W-1:0];
                CFG_RELAX:    cfg_reg.relaxation_factor    <= cfg_data[GAIN_W-1:0];
                CFG_MAX_PUSH: cfg_reg.max_push_coefficient <= cfg_data[GAIN_W-1:0];
                CFG_MAX_NBR:  cfg_reg.max_neighbors        <= cfg_data[NBR_W-1:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    pcca_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_ch    (in_ch),
        .push_job (push_job),
        .push     (push),
        .full     (full)
    );

    pcca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    pcca_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .avail  (avail),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire
